>>> hdl/bol_pkg.sv
package bol_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int DATA_W           = 32;
   localparam int OP_W             = 3;
   localparam int POS_W            = 8;
   localparam int RSP_COUNT_W      = 5;

   localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_INSERT     = 3'd4,
      OP_REMOVE     = 3'd5,
      OP_FIND       = 3'd6
   } op_type;

   // per-cycle command broadcast along the cell row
   typedef struct packed {
      logic insert;
      logic drop;
      logic find;
   } cell_ctl_type;

endpackage

>>> hdl/bol_cell.sv
module bol_cell #(
   parameter int CW  = 5,
   parameter int IDX = 0
) (
   input  logic                          clock,
   input  bol_pkg::cell_ctl_type         ctl,
   input  logic [CW-1:0]                 pos,
   input  logic [CW-1:0]                 count,
   input  logic [bol_pkg::DATA_W-1:0]    value,
   input  logic [bol_pkg::DATA_W-1:0]    left_data,
   input  logic [bol_pkg::DATA_W-1:0]    right_data,
   output logic [bol_pkg::DATA_W-1:0]    data_out,
   output logic                          match_out
);
   import bol_pkg::*;

   localparam logic [CW-1:0] IDX_C = CW'(IDX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              match_ff;
   logic              match_in;

   // take from the left to open a gap, from the right to close one
   always_comb begin
      data_in = data_ff;
      if (ctl.insert) begin
         if (IDX_C > pos) begin
            data_in = left_data;
         end else if (IDX_C == pos) begin
            data_in = value;
         end
      end else if (ctl.drop) begin
         if (IDX_C >= pos) begin
            data_in = right_data;
         end
      end
   end

   assign match_in = ctl.find && (IDX_C < count) && (data_ff == value);

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data_out  = data_ff;
   assign match_out = match_ff;

endmodule

>>> hdl/bounded_ordered_list.sv
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_op, req_position, req_value
// rsp       out        rsp_valid, rsp_ready, rsp_ok, rsp_found_position,
//                      rsp_front_value, rsp_back_value, rsp_entry_total, rsp_is_empty
//
// A request first shifts the cell row (insert, push, pop, remove) or compares
// it (find) all at once; then the front, back and first-match position are
// gathered into the response register.
// A new request is taken once the last one has been gathered and that register
// is free or being emptied, so requests never overlap inside the block.
// Reset is synchronous: it clears the count and the handshake state only; cell
// contents stay undefined until written, and there is no clearing pass.
// A stalled response holds its fields and blocks new requests.
module bounded_ordered_list #(
   parameter int CAPACITY = bol_pkg::DEFAULT_CAPACITY
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [bol_pkg::OP_W-1:0]                 req_op,
   input  logic [bol_pkg::POS_W-1:0]                req_position,
   input  logic signed [bol_pkg::DATA_W-1:0]        req_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_ok,
   output logic [bol_pkg::RSP_COUNT_W-1:0]          rsp_found_position,
   output logic signed [bol_pkg::DATA_W-1:0]        rsp_front_value,
   output logic signed [bol_pkg::DATA_W-1:0]        rsp_back_value,
   output logic [bol_pkg::RSP_COUNT_W-1:0]          rsp_entry_total,
   output logic                                     rsp_is_empty
);
   import bol_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam int XW = (CW > RSP_COUNT_W) ? CW : RSP_COUNT_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   // handshake and count
   logic          busy_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          accept;

   // request decode, held for the gather cycle
   logic          find_ff;
   logic          ok_ff;
   logic          ok_in;
   cell_ctl_type  cell_ctl;
   logic [CW-1:0] cell_pos;

   logic [PW-1:0] count_w;
   logic [PW-1:0] pos_w;
   logic [PW-1:0] clamp_w;
   logic          full;
   logic          empty;

   // cell row
   logic [DATA_W-1:0] data_vec  [CAPACITY];
   logic [DATA_W-1:0] left_vec  [CAPACITY];
   logic [DATA_W-1:0] right_vec [CAPACITY];
   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] first_vec;

   // gather
   logic [XW-1:0]     hit_idx;
   logic [XW-1:0]     count_x;
   logic [DATA_W-1:0] back_acc;
   logic [CW-1:0]     last_pos;

   // response register
   logic                   rsp_valid_ff;
   logic                   rsp_ok_ff;
   logic [RSP_COUNT_W-1:0] rsp_found_ff;
   logic [DATA_W-1:0]      rsp_front_ff;
   logic [DATA_W-1:0]      rsp_back_ff;
   logic [RSP_COUNT_W-1:0] rsp_total_ff;
   logic                   rsp_empty_ff;

   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign count_w = PW'(count_ff);
   assign pos_w   = PW'(req_position);
   assign clamp_w = (pos_w > count_w) ? count_w : pos_w;
   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);

   // decode the request into a shift command for the row; refused commands
   // leave the row untouched
   always_comb begin
      cell_ctl = '0;
      cell_pos = '0;
      ok_in    = 1'b0;
      if (accept) begin
         case (op_type'(req_op))
            OP_PUSH_FRONT: begin
               if (!full) begin
                  cell_ctl.insert = 1'b1;
                  ok_in           = 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (!full) begin
                  cell_ctl.insert = 1'b1;
                  cell_pos        = count_ff;
                  ok_in           = 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (!empty) begin
                  cell_ctl.drop = 1'b1;
                  ok_in         = 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (!empty) begin
                  cell_ctl.drop = 1'b1;
                  cell_pos      = count_ff - CW'(1);
                  ok_in         = 1'b1;
               end
            end
            OP_INSERT: begin
               // past the end appends
               if (!full) begin
                  cell_ctl.insert = 1'b1;
                  cell_pos        = CW'(clamp_w);
                  ok_in           = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (pos_w < count_w) begin
                  cell_ctl.drop = 1'b1;
                  cell_pos      = CW'(pos_w);
                  ok_in         = 1'b1;
               end
            end
            OP_FIND: begin
               cell_ctl.find = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cell_ctl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cell_ctl.drop) begin
         count_in = count_ff - CW'(1);
      end
   end

   // cell row: cell 0 is the front
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_left_edge
         assign left_vec[g] = req_value;
      end else begin : g_left_inner
         assign left_vec[g] = data_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_right_edge
         assign right_vec[g] = data_vec[g];
      end else begin : g_right_inner
         assign right_vec[g] = data_vec[g+1];
      end

      bol_cell #(
         .CW  (CW),
         .IDX (g)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .pos        (cell_pos),
         .count      (count_ff),
         .value      (req_value),
         .left_data  (left_vec[g]),
         .right_data (right_vec[g]),
         .data_out   (data_vec[g]),
         .match_out  (match_vec[g])
      );
   end

   // isolate the frontmost match, then encode it; pick the back by position
   assign first_vec = match_vec & (~match_vec + CAPACITY'(1));
   assign last_pos  = count_ff - CW'(1);
   assign count_x   = XW'(count_ff);

   always_comb begin
      hit_idx  = '0;
      back_acc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_vec[i]) begin
            hit_idx = hit_idx | XW'(i);
         end
         if (CW'(i) == last_pos) begin
            back_acc = back_acc | data_vec[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff  <= accept;
         count_ff <= count_in;
         if (busy_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the decode across the shift cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         find_ff <= cell_ctl.find;
         ok_ff   <= ok_in;
      end
   end

   // gather into the response register
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         if (find_ff) begin
            rsp_ok_ff <= |match_vec;
         end else begin
            rsp_ok_ff <= ok_ff;
         end
         if (find_ff && (|match_vec)) begin
            rsp_found_ff <= hit_idx[RSP_COUNT_W-1:0];
         end else begin
            rsp_found_ff <= count_x[RSP_COUNT_W-1:0];
         end
         rsp_front_ff <= empty ? EMPTY_VALUE : data_vec[0];
         rsp_back_ff  <= empty ? EMPTY_VALUE : back_acc;
         rsp_total_ff <= count_x[RSP_COUNT_W-1:0];
         rsp_empty_ff <= empty;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_front_value    = rsp_front_ff;
   assign rsp_back_value     = rsp_back_ff;
   assign rsp_entry_total    = rsp_total_ff;
   assign rsp_is_empty       = rsp_empty_ff;

endmodule

>>> hdl/bol_checker.sv
module bol_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic [bol_pkg::OP_W-1:0]              req_op,
   input logic [bol_pkg::POS_W-1:0]             req_position,
   input logic signed [bol_pkg::DATA_W-1:0]     req_value,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_ok,
   input logic [bol_pkg::RSP_COUNT_W-1:0]       rsp_found_position,
   input logic signed [bol_pkg::DATA_W-1:0]     rsp_front_value,
   input logic signed [bol_pkg::DATA_W-1:0]     rsp_back_value,
   input logic [bol_pkg::RSP_COUNT_W-1:0]       rsp_entry_total,
   input logic                                  rsp_is_empty
);
   import bol_pkg::*;

   // empty flag agrees with the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_total == '0)))
      else $error("empty flag disagrees with entry total");

   // an empty list shows the empty mark at both ends
   a_empty_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |->
         (rsp_front_value == EMPTY_VALUE) && (rsp_back_value == EMPTY_VALUE))
      else $error("empty list shows a stale front or back");

   // a match lies inside the list; otherwise the position is the count
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found_position <= rsp_entry_total))
      else $error("found position beyond entry total");

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (.*);
